// ===== rtl/core/rtz_pkg.sv =====
// ----------------------------------------------------------------------------
// rtz_pkg
// Shared types and codes of the triangle rasterizer core.
// ----------------------------------------------------------------------------
package rtz_pkg;

   localparam int COLOR_BITS   = 24;
   localparam int ACT_BITS     = 2;
   localparam int DIM_BITS     = 9;
   localparam int CFG_IDX_BITS = 2;

   localparam logic [ACT_BITS-1:0] ACT_DRAW   = 2'd0;
   localparam logic [ACT_BITS-1:0] ACT_READ   = 2'd1;
   localparam logic [ACT_BITS-1:0] ACT_WRITE  = 2'd2;
   localparam logic [ACT_BITS-1:0] ACT_UNUSED = 2'd3;

   localparam logic [CFG_IDX_BITS-1:0] CFG_EDGE_COLOR   = 2'd0;
   localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH  = 2'd1;
   localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT = 2'd2;

   localparam logic [DIM_BITS-1:0] DIM_RESET = 9'd200;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WIND,
      ST_INIT,
      ST_FILL,
      ST_LSETUP,
      ST_LWALK,
      ST_WRITE,
      ST_RD_ADDR,
      ST_RD_DATA
   } rtz_state_type;

   typedef enum logic [1:0] {
      LN_SHALLOW_UP,
      LN_STEEP_UP,
      LN_SHALLOW_DN,
      LN_STEEP_DN
   } rtz_line_type;

   typedef struct packed {
      logic                  load;
      logic [COLOR_BITS-1:0] color;
   } rtz_rsp_type;

endpackage

// ===== rtl/core/rtz_frame_mem.sv =====
// ----------------------------------------------------------------------------
// rtz_frame_mem
// Single-port framebuffer memory, one access per cycle, registered read.
// ----------------------------------------------------------------------------
module rtz_frame_mem #(
   parameter int DEPTH = 65536,
   parameter int AW    = 16,
   parameter int DW    = 24
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] addr,
   input  logic [DW-1:0] wdata,
   output logic [DW-1:0] rdata
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/rtz_edge_unit.sv =====
// ----------------------------------------------------------------------------
// rtz_edge_unit
// Edge cross product (b - a) x (p - a), shared by winding test and setup.
// ----------------------------------------------------------------------------
module rtz_edge_unit #(
   parameter int CB = 11
) (
   input  logic signed [CB-1:0]   ax,
   input  logic signed [CB-1:0]   ay,
   input  logic signed [CB-1:0]   bx,
   input  logic signed [CB-1:0]   by,
   input  logic signed [CB-1:0]   px,
   input  logic signed [CB-1:0]   py,
   output logic signed [2*CB+2:0] value
);

   logic signed [CB:0]     dbx, dby, dpx, dpy;
   logic signed [2*CB+1:0] prod_a, prod_b;

   always_comb begin
      dbx    = (CB+1)'(bx) - (CB+1)'(ax);
      dby    = (CB+1)'(by) - (CB+1)'(ay);
      dpx    = (CB+1)'(px) - (CB+1)'(ax);
      dpy    = (CB+1)'(py) - (CB+1)'(ay);
      prod_a = dbx * dpy;
      prod_b = dby * dpx;
      value  = (2*CB+3)'(prod_a) - (2*CB+3)'(prod_b);
   end

endmodule

// ===== rtl/core/rtz_engine.sv =====
// ----------------------------------------------------------------------------
// rtz_engine
// Command sequencer: winding, edge setup, box fill, outline walk, pixel access.
// ----------------------------------------------------------------------------
module rtz_engine #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int CB         = 11
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             cmd_valid,
   output logic                             cmd_ready,
   input  logic [rtz_pkg::ACT_BITS-1:0]     cmd_action,
   input  logic signed [CB-1:0]             cmd_x0,
   input  logic signed [CB-1:0]             cmd_y0,
   input  logic signed [CB-1:0]             cmd_x1,
   input  logic signed [CB-1:0]             cmd_y1,
   input  logic signed [CB-1:0]             cmd_x2,
   input  logic signed [CB-1:0]             cmd_y2,
   input  logic [rtz_pkg::COLOR_BITS-1:0]   cmd_color,
   input  logic [rtz_pkg::COLOR_BITS-1:0]   edge_color,
   input  logic [rtz_pkg::DIM_BITS-1:0]     image_width,
   input  logic [rtz_pkg::DIM_BITS-1:0]     image_height,
   input  logic                             rsp_free,
   output rtz_pkg::rtz_rsp_type             rsp
);
   import rtz_pkg::*;

   localparam int CW    = (CB + 2 > 12) ? CB + 2 : 12;
   localparam int EW    = 2 * CB + 3;
   localparam int EB    = CB + 4;
   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);

   rtz_state_type state_ff, state_in;
   rtz_line_type  cls_ff, cls_in;

   logic signed [CB-1:0] vx0_ff, vy0_ff, vx1_ff, vy1_ff, vx2_ff, vy2_ff;
   logic signed [CB-1:0] vx0_in, vy0_in, vx1_in, vy1_in, vx2_in, vy2_in;
   logic [COLOR_BITS-1:0] face_ff, face_in;
   logic signed [CB-1:0] lox_ff, hix_ff, loy_ff, hiy_ff;
   logic signed [CB-1:0] lox_in, hix_in, loy_in, hiy_in;
   logic signed [EW-1:0] e_ff [3];
   logic signed [EW-1:0] e_in [3];
   logic signed [EW-1:0] erow_ff [3];
   logic signed [EW-1:0] erow_in [3];
   logic [1:0] init_k_ff, init_k_in, line_k_ff, line_k_in;
   logic signed [CB-1:0] scan_x_ff, scan_y_ff, scan_x_in, scan_y_in;
   logic signed [CB-1:0] end_x_ff, end_y_ff, end_x_in, end_y_in;
   logic signed [CB:0]   ldx_ff, ldy_ff, ldx_in, ldy_in;
   logic signed [EB-1:0] err_ff, err_in;

   // command decode and bounding box
   logic signed [CB-1:0] minx, maxx, miny, maxy, box_lox, box_hix, box_loy, box_hiy;
   logic signed [CW-1:0] lim_w, lim_h, hix_w, hiy_w;
   logic                 box_empty;
   logic                 accept;

   // shared edge unit
   logic signed [CB-1:0] eu_ax, eu_ay, eu_bx, eu_by, eu_px, eu_py;
   logic signed [EW-1:0] eu_val;

   // line setup
   logic signed [CB-1:0] la_x, la_y, lb_x, lb_y, sx, sy, ex, ey;
   logic signed [CB:0]   dx, dy;
   rtz_line_type         cls_new;
   logic signed [EB-1:0] err_new, wdx, wdy;

   // pixel side
   logic                  in_win, fill_hit, x_last, y_last, line_done;
   logic                  mem_we;
   logic [AW-1:0]         mem_addr;
   logic [COLOR_BITS-1:0] mem_wdata, mem_rdata;
   logic signed [EW-1:0]  dxe [3];
   logic signed [EW-1:0]  dye [3];

   assign accept = cmd_valid && cmd_ready;

   always_comb begin
      lim_w = (CW'(image_width) < CW'(MAX_WIDTH))  ? CW'(image_width)  : CW'(MAX_WIDTH);
      lim_h = (CW'(image_height) < CW'(MAX_HEIGHT)) ? CW'(image_height) : CW'(MAX_HEIGHT);
      minx  = (cmd_x0 < cmd_x1) ? cmd_x0 : cmd_x1;
      minx  = (cmd_x2 < minx) ? cmd_x2 : minx;
      maxx  = (cmd_x0 > cmd_x1) ? cmd_x0 : cmd_x1;
      maxx  = (cmd_x2 > maxx) ? cmd_x2 : maxx;
      miny  = (cmd_y0 < cmd_y1) ? cmd_y0 : cmd_y1;
      miny  = (cmd_y2 < miny) ? cmd_y2 : miny;
      maxy  = (cmd_y0 > cmd_y1) ? cmd_y0 : cmd_y1;
      maxy  = (cmd_y2 > maxy) ? cmd_y2 : maxy;
      box_lox = (minx < 0) ? '0 : minx;
      box_loy = (miny < 0) ? '0 : miny;
      hix_w   = (CW'(maxx) > lim_w - 1) ? lim_w - 1 : CW'(maxx);
      hiy_w   = (CW'(maxy) > lim_h - 1) ? lim_h - 1 : CW'(maxy);
      box_hix = CB'(hix_w);
      box_hiy = CB'(hiy_w);
   end

   assign box_empty = (lox_ff > hix_ff) || (loy_ff > hiy_ff);

   // per-edge step terms: x step subtracts dy, y step adds dx
   always_comb begin
      dxe[0] = EW'(vx1_ff) - EW'(vx0_ff);
      dye[0] = EW'(vy1_ff) - EW'(vy0_ff);
      dxe[1] = EW'(vx2_ff) - EW'(vx1_ff);
      dye[1] = EW'(vy2_ff) - EW'(vy1_ff);
      dxe[2] = EW'(vx0_ff) - EW'(vx2_ff);
      dye[2] = EW'(vy0_ff) - EW'(vy2_ff);
   end

   always_comb begin
      eu_px = lox_ff;
      eu_py = loy_ff;
      case (init_k_ff)
         2'd1: begin
            eu_ax = vx1_ff; eu_ay = vy1_ff; eu_bx = vx2_ff; eu_by = vy2_ff;
         end
         2'd2: begin
            eu_ax = vx2_ff; eu_ay = vy2_ff; eu_bx = vx0_ff; eu_by = vy0_ff;
         end
         default: begin
            eu_ax = vx0_ff; eu_ay = vy0_ff; eu_bx = vx1_ff; eu_by = vy1_ff;
         end
      endcase
      if (state_ff == ST_WIND) begin
         eu_ax = vx0_ff; eu_ay = vy0_ff; eu_bx = vx1_ff; eu_by = vy1_ff;
         eu_px = vx2_ff; eu_py = vy2_ff;
      end
   end

   rtz_edge_unit #(.CB(CB)) u_edge (
      .ax(eu_ax), .ay(eu_ay), .bx(eu_bx), .by(eu_by), .px(eu_px), .py(eu_py),
      .value(eu_val)
   );

   // outline setup
   always_comb begin
      case (line_k_ff)
         2'd1: begin
            la_x = vx1_ff; la_y = vy1_ff; lb_x = vx2_ff; lb_y = vy2_ff;
         end
         2'd2: begin
            la_x = vx2_ff; la_y = vy2_ff; lb_x = vx0_ff; lb_y = vy0_ff;
         end
         default: begin
            la_x = vx0_ff; la_y = vy0_ff; lb_x = vx1_ff; lb_y = vy1_ff;
         end
      endcase
      if (lb_x < la_x) begin
         sx = lb_x; sy = lb_y; ex = la_x; ey = la_y;
      end else begin
         sx = la_x; sy = la_y; ex = lb_x; ey = lb_y;
      end
      dx = (CB+1)'(ex) - (CB+1)'(sx);
      dy = (CB+1)'(ey) - (CB+1)'(sy);
      if (dx > 0 && dy >= 0 && dy <= dx) begin
         cls_new = LN_SHALLOW_UP;
         err_new = (EB'(dy) <<< 1) - EB'(dx);
      end else if (dy > dx) begin
         cls_new = LN_STEEP_UP;
         err_new = EB'(dy) - (EB'(dx) <<< 1);
      end else if (dx > 0 && dy < 0 && -dy <= dx) begin
         cls_new = LN_SHALLOW_DN;
         err_new = (EB'(dy) <<< 1) + EB'(dx);
      end else begin
         cls_new = LN_STEEP_DN;
         err_new = EB'(dy) + (EB'(dx) <<< 1);
      end
   end

   assign wdx = EB'(ldx_ff);
   assign wdy = EB'(ldy_ff);

   always_comb begin
      in_win = (CW'(scan_x_ff) >= 0) && (CW'(scan_x_ff) < lim_w) &&
               (CW'(scan_y_ff) >= 0) && (CW'(scan_y_ff) < lim_h);
      fill_hit = !e_ff[0][EW-1] && !e_ff[1][EW-1] && !e_ff[2][EW-1];
      x_last   = (scan_x_ff == hix_ff);
      y_last   = (scan_y_ff == hiy_ff);
      if (cls_ff == LN_SHALLOW_UP || cls_ff == LN_SHALLOW_DN) begin
         line_done = (scan_x_ff == end_x_ff);
      end else begin
         line_done = (scan_y_ff == end_y_ff);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (cmd_action)
                  ACT_DRAW:  state_in = ST_WIND;
                  ACT_READ:  state_in = ST_RD_ADDR;
                  ACT_WRITE: state_in = ST_WRITE;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_WIND:    state_in = ST_INIT;
         ST_INIT: begin
            if (init_k_ff == 2'd2) begin
               state_in = box_empty ? ST_LSETUP : ST_FILL;
            end
         end
         ST_FILL: begin
            if (x_last && y_last) begin
               state_in = ST_LSETUP;
            end
         end
         ST_LSETUP:  state_in = ST_LWALK;
         ST_LWALK: begin
            if (line_done) begin
               state_in = (line_k_ff == 2'd2) ? ST_IDLE : ST_LSETUP;
            end
         end
         ST_WRITE:   state_in = ST_IDLE;
         ST_RD_ADDR: state_in = ST_RD_DATA;
         ST_RD_DATA: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   // outputs: memory access, response, ready
   always_comb begin
      cmd_ready = (state_ff == ST_IDLE);
      mem_we    = 1'b0;
      mem_wdata = edge_color;
      rsp.load  = 1'b0;
      rsp.color = in_win ? mem_rdata : '0;
      case (state_ff)
         ST_FILL: begin
            mem_we    = fill_hit;
            mem_wdata = face_ff;
         end
         ST_LWALK:   mem_we = in_win;
         ST_WRITE: begin
            mem_we    = in_win;
            mem_wdata = face_ff;
         end
         ST_RD_DATA: rsp.load = rsp_free;
         default:    mem_we = 1'b0;
      endcase
      mem_addr = AW'(32'(unsigned'(scan_y_ff)) * MAX_WIDTH + 32'(unsigned'(scan_x_ff)));
   end

   rtz_frame_mem #(.DEPTH(DEPTH), .AW(AW), .DW(COLOR_BITS)) u_mem (
      .clock(clock), .we(mem_we), .addr(mem_addr), .wdata(mem_wdata), .rdata(mem_rdata)
   );

   // datapath
   always_comb begin
      vx0_in = vx0_ff; vy0_in = vy0_ff; vx1_in = vx1_ff;
      vy1_in = vy1_ff; vx2_in = vx2_ff; vy2_in = vy2_ff;
      face_in = face_ff;
      lox_in = lox_ff; hix_in = hix_ff; loy_in = loy_ff; hiy_in = hiy_ff;
      e_in = e_ff;
      erow_in = erow_ff;
      init_k_in = init_k_ff;
      line_k_in = line_k_ff;
      scan_x_in = scan_x_ff; scan_y_in = scan_y_ff;
      end_x_in = end_x_ff; end_y_in = end_y_ff;
      ldx_in = ldx_ff; ldy_in = ldy_ff;
      cls_in = cls_ff;
      err_in = err_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               vx0_in = cmd_x0; vy0_in = cmd_y0; vx1_in = cmd_x1;
               vy1_in = cmd_y1; vx2_in = cmd_x2; vy2_in = cmd_y2;
               face_in = cmd_color;
               lox_in = box_lox; hix_in = box_hix; loy_in = box_loy; hiy_in = box_hiy;
               scan_x_in = cmd_x0;
               scan_y_in = cmd_y0;
               init_k_in = 2'd0;
               line_k_in = 2'd0;
            end
         end
         ST_WIND: begin
            // negative winding: swap second and third vertex
            if (eu_val < 0) begin
               vx1_in = vx2_ff; vy1_in = vy2_ff;
               vx2_in = vx1_ff; vy2_in = vy1_ff;
            end
         end
         ST_INIT: begin
            e_in[init_k_ff]    = eu_val;
            erow_in[init_k_ff] = eu_val;
            init_k_in          = init_k_ff + 2'd1;
            scan_x_in          = lox_ff;
            scan_y_in          = loy_ff;
         end
         ST_FILL: begin
            if (x_last) begin
               scan_x_in = lox_ff;
               scan_y_in = scan_y_ff + 1'b1;
               for (int i = 0; i < 3; i++) begin
                  erow_in[i] = erow_ff[i] + dxe[i];
                  e_in[i]    = erow_ff[i] + dxe[i];
               end
            end else begin
               scan_x_in = scan_x_ff + 1'b1;
               for (int i = 0; i < 3; i++) begin
                  e_in[i] = e_ff[i] - dye[i];
               end
            end
         end
         ST_LSETUP: begin
            scan_x_in = sx; scan_y_in = sy;
            end_x_in  = ex; end_y_in  = ey;
            ldx_in    = dx; ldy_in    = dy;
            cls_in    = cls_new;
            err_in    = err_new;
         end
         ST_LWALK: begin
            if (line_done) begin
               line_k_in = line_k_ff + 2'd1;
            end else begin
               case (cls_ff)
                  LN_SHALLOW_UP: begin
                     scan_x_in = scan_x_ff + 1'b1;
                     if (err_ff > 0) begin
                        err_in    = err_ff + ((wdy - wdx) <<< 1);
                        scan_y_in = scan_y_ff + 1'b1;
                     end else begin
                        err_in = err_ff + (wdy <<< 1);
                     end
                  end
                  LN_STEEP_UP: begin
                     scan_y_in = scan_y_ff + 1'b1;
                     if (err_ff <= 0) begin
                        err_in    = err_ff + ((wdy - wdx) <<< 1);
                        scan_x_in = scan_x_ff + 1'b1;
                     end else begin
                        err_in = err_ff - (wdx <<< 1);
                     end
                  end
                  LN_SHALLOW_DN: begin
                     scan_x_in = scan_x_ff + 1'b1;
                     if (err_ff < 0) begin
                        err_in    = err_ff + ((wdy + wdx) <<< 1);
                        scan_y_in = scan_y_ff - 1'b1;
                     end else begin
                        err_in = err_ff + (wdy <<< 1);
                     end
                  end
                  default: begin
                     scan_y_in = scan_y_ff - 1'b1;
                     if (err_ff > 0) begin
                        err_in    = err_ff + ((wdy + wdx) <<< 1);
                        scan_x_in = scan_x_ff + 1'b1;
                     end else begin
                        err_in = err_ff + (wdx <<< 1);
                     end
                  end
               endcase
            end
         end
         default: begin
            err_in = err_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         scan_x_ff <= '0;
         scan_y_ff <= '0;
         err_ff    <= '0;
         init_k_ff <= '0;
         line_k_ff <= '0;
      end else begin
         state_ff  <= state_in;
         scan_x_ff <= scan_x_in;
         scan_y_ff <= scan_y_in;
         err_ff    <= err_in;
         init_k_ff <= init_k_in;
         line_k_ff <= line_k_in;
      end
   end

   always_ff @(posedge clock) begin
      vx0_ff <= vx0_in; vy0_ff <= vy0_in; vx1_ff <= vx1_in;
      vy1_ff <= vy1_in; vx2_ff <= vx2_in; vy2_ff <= vy2_in;
      face_ff <= face_in;
      lox_ff <= lox_in; hix_ff <= hix_in; loy_ff <= loy_in; hiy_ff <= hiy_in;
      e_ff <= e_in;
      erow_ff <= erow_in;
      end_x_ff <= end_x_in; end_y_ff <= end_y_in;
      ldx_ff <= ldx_in; ldy_ff <= ldy_in;
      cls_ff <= cls_in;
   end

endmodule

// ===== rtl/core/triangle_rasterizer_with_edges_core.sv =====
// ----------------------------------------------------------------------------
// triangle_rasterizer_with_edges_core
// Filled triangle rasterizer with outlined edges over an RGB framebuffer.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Transaction
// req_*     in         command: action in tuser, vertices and colour in tdata
// rsp_*     out        pixel colour, one per read command
// csr_*     in         register write: 0 edge colour, 1 width, 2 height
//
// A draw runs winding and edge setup, a fill step for each bounding-box
// pixel (inside the clip window), then per edge a setup step and a walk step
// per outline pixel; the single framebuffer port sets the pace. A pixel write
// passes ST_WRITE, a read ST_RD_ADDR and ST_RD_DATA. Reset is synchronous and
// clears control state; the framebuffer holds garbage until written. A read
// result waits in the output register while the next command is taken; a
// second read waits in the engine until that register drains.
//
module triangle_rasterizer_with_edges_core #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int COORD_BITS = 11
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // x0, y0, x1, y1, x2, y2, face_color, zero fill
   input  logic [((6*COORD_BITS+rtz_pkg::COLOR_BITS+7)/8)*8-1:0] req_tdata,
   // action
   input  logic [rtz_pkg::ACT_BITS-1:0]        req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // pixel_color
   output logic [rtz_pkg::COLOR_BITS-1:0]      rsp_tdata,
   input  logic                                csr_wr_en,
   input  logic [rtz_pkg::CFG_IDX_BITS-1:0]    csr_index,
   input  logic [rtz_pkg::COLOR_BITS-1:0]      csr_wdata
);
   import rtz_pkg::*;

   localparam int CB = COORD_BITS;

   logic [COLOR_BITS-1:0] edge_color_ff;
   logic [DIM_BITS-1:0]   image_width_ff, image_height_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COLOR_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_free;
   rtz_rsp_type           eng_rsp;

   // register file: the user must write it only while the engine is idle; the block does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         edge_color_ff   <= '0;
         image_width_ff  <= DIM_RESET;
         image_height_ff <= DIM_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CFG_EDGE_COLOR:   edge_color_ff   <= csr_wdata;
            CFG_IMAGE_WIDTH:  image_width_ff  <= csr_wdata[DIM_BITS-1:0];
            CFG_IMAGE_HEIGHT: image_height_ff <= csr_wdata[DIM_BITS-1:0];
            default:          edge_color_ff   <= edge_color_ff;
         endcase
      end
   end

   // the output slot can take a new result when empty or draining this cycle
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   rtz_engine #(
      .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .CB(CB)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .cmd_valid    (req_tvalid),
      .cmd_ready    (req_tready),
      .cmd_action   (req_tuser),
      .cmd_x0       (signed'(req_tdata[CB-1:0])),
      .cmd_y0       (signed'(req_tdata[2*CB-1:CB])),
      .cmd_x1       (signed'(req_tdata[3*CB-1:2*CB])),
      .cmd_y1       (signed'(req_tdata[4*CB-1:3*CB])),
      .cmd_x2       (signed'(req_tdata[5*CB-1:4*CB])),
      .cmd_y2       (signed'(req_tdata[6*CB-1:5*CB])),
      .cmd_color    (req_tdata[6*CB+COLOR_BITS-1:6*CB]),
      .edge_color   (edge_color_ff),
      .image_width  (image_width_ff),
      .image_height (image_height_ff),
      .rsp_free     (rsp_free),
      .rsp          (eng_rsp)
   );

   // output register: load a new result, drop the old one once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (eng_rsp.load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = eng_rsp.color;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
